>>> rtl/ssit_pkg.sv
// Package with types and constants shared by the smallest-sum insertion tour block.
package ssit_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;
  localparam int DistW     = 26;
  localparam int SumW      = DistW + IdxW + 2;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0] tour_vertex;
    logic       last_vertex;
    logic       status;
  } out_item_t;

  // Shift command broadcast to the row of tour cells.
  typedef struct packed {
    logic            init;
    logic            insert;
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] vtx;
  } ssit_cell_ctl_t;

endpackage

>>> rtl/ssit_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module ssit_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [41:0]       radicand,
  output logic              done,
  output logic [25:0]       root
);
  import ssit_pkg::*;

  logic [29:0] rem_r, rem_nxt;
  logic [51:0] rad_r, rad_nxt;
  logic [25:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [29:0] v;
  logic [29:0] trial;
  logic [25:0] r1;

  // One restoring step: bring down the next two radicand bits and try 4*res+1.
  always_comb begin
    rem_nxt  = rem_r;
    rad_nxt  = rad_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    v        = '0;
    trial    = '0;
    r1       = '0;
    if (start) begin
      rem_nxt  = '0;
      rad_nxt  = {10'd0, radicand};
      res_nxt  = '0;
      cnt_nxt  = 5'd26;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder never exceeds twice the partial root, so 28 bits hold it.
      v     = {rem_r[27:0], rad_r[51:50]};
      trial = {2'b00, res_r, 2'b01};
      r1    = res_r;
      if (v >= trial) begin
        v  = v - trial;
        r1 = {res_r[24:0], 1'b1};
      end else begin
        r1 = {res_r[24:0], 1'b0};
      end
      rem_nxt = v;
      rad_nxt = {rad_r[49:0], 2'b00};
      res_nxt = r1;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    rad_r <= rad_nxt;
    res_r <= res_nxt;
  end

  assign done = busy_r && (cnt_r == 5'd1);
  assign root = res_nxt;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("sqrt started while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r) else $error("sqrt busy after done");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == 5'd26) else $error("sqrt bad start");
`endif

endmodule

>>> rtl/ssit_cell.sv
// One tour cell: holds a tour entry, taking the new or left one on insertion.
module ssit_cell (
  input  logic                        clk,
  input  ssit_pkg::ssit_cell_ctl_t    ctl,
  input  logic [ssit_pkg::IdxW-1:0]   my_pos,
  input  logic [ssit_pkg::IdxW-1:0]   left_vtx,
  output logic [ssit_pkg::IdxW-1:0]   vtx
);
  import ssit_pkg::*;

  logic [IdxW-1:0] vtx_r, vtx_nxt;

  always_comb begin
    vtx_nxt = vtx_r;
    if (ctl.init) begin
      vtx_nxt = '0;
    end else if (ctl.insert) begin
      if (my_pos == ctl.pos) vtx_nxt = ctl.vtx;
      else if (my_pos > ctl.pos) vtx_nxt = left_vtx;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
  end

  assign vtx = vtx_r;
endmodule

>>> rtl/smallest_sum_insertion_tour.sv
// Top level of the smallest-sum insertion tour builder.
//  channel | ports                     | direction
//  input   | in_valid/in_ready/in_data | points, one per transaction
//  output  | out_valid/out_ready/out_data | tour entries in order
// After the last point the distance table is built pair by pair: the coordinate,
// difference, square and squared-sum registers fill, a start state launches the
// iterative square root and its result is written. Each of N-1 steps with a tour of
// length L sums L distance reads per unvisited point, skips visited points, then
// makes three reads per tour edge for costs and inserts. The tour is a row of cells
// shifted on each insertion; output drains one entry per accepted transaction.
// Reset is synchronous; no items are taken while computing or emitting.
module smallest_sum_insertion_tour (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ssit_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssit_pkg::out_item_t   out_data
);
  import ssit_pkg::*;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_DPAIR = 10'b0000000010,
    S_DSQ   = 10'b0000000100,
    S_DRT   = 10'b0000001000,
    S_SUM   = 10'b0000010000,
    S_SACC  = 10'b0000100000,
    S_COST  = 10'b0001000000,
    S_CACC  = 10'b0010000000,
    S_INS   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] xs [MaxPoints];
  logic [15:0] ys [MaxPoints];
  logic [DistW-1:0] dmem [MaxPoints*MaxPoints];

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [MaxPoints-1:0] vis_r, vis_nxt;
  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CntW-1:0] len_r, len_nxt;
  logic [CntW-1:0] k_r, k_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [SumW-1:0] acc_r, acc_nxt, best_r, best_nxt;
  logic            found_r, found_nxt;
  logic [IdxW-1:0] bv_r, bv_nxt, bk_r, bk_nxt;
  logic signed [SumW:0] cst_r, cst_nxt, bc_r, bc_nxt;
  logic [CntW-1:0] e_r, e_nxt;
  logic            rd_v_r, rd_v_nxt;
  logic [1:0]      rd_ph_r, rd_ph_nxt;
  logic            rd_lastk_r, rd_lastk_nxt;
  logic [IdxW-1:0] rd_k_r, rd_k_nxt;

  logic [2*IdxW-1:0] raddr;
  logic [DistW-1:0]  rdata_r;
  logic [15:0] xi_r, xj_r, yi_r, yj_r;
  logic signed [16:0] dx_r, dy_r;
  logic [41:0] sq_r;
  logic sq_start, sq_done;
  logic [25:0] sq_root;
  logic dwe;

  ssit_cell_ctl_t ctl;
  logic [IdxW-1:0] tour [MaxPoints];

  genvar g;
  generate
    for (g = 0; g < MaxPoints; g++) begin : g_cell
      ssit_cell u_cell (
        .clk(clk), .ctl(ctl), .my_pos(IdxW'(g)),
        .left_vtx((g == 0) ? tour[0] : tour[(g == 0) ? 0 : g-1]),
        .vtx(tour[g]));
    end
  endgenerate

  ssit_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_r),
    .done(sq_done), .root(sq_root));

  logic [IdxW-1:0] tk, tk1;
  assign tk  = tour[k_r[IdxW-1:0]];
  assign tk1 = (k_r + 1'b1 == len_r) ? tour[0] : tour[IdxW'(k_r + 1'b1)];

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_valid && cnt_r < CntW'(MaxPoints)) begin
      xs[cnt_r[IdxW-1:0]] <= in_data.x_coord;
      ys[cnt_r[IdxW-1:0]] <= in_data.y_coord;
    end
    xi_r <= xs[i_r]; xj_r <= xs[j_r];
    yi_r <= ys[i_r]; yj_r <= ys[j_r];
    if (dwe) dmem[{i_r, j_r}] <= sq_root;
    rdata_r <= dmem[raddr];
  end

  logic [33:0] px, py;
  always_ff @(posedge clk) begin
    dx_r <= $signed({xi_r[15], xi_r}) - $signed({xj_r[15], xj_r});
    dy_r <= $signed({yi_r[15], yi_r}) - $signed({yj_r[15], yj_r});
    px   <= 34'(dx_r * dx_r);
    py   <= 34'(dy_r * dy_r);
    sq_r <= {(px + py), 8'd0} ;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; vis_nxt = vis_r;
    i_nxt = i_r; j_nxt = j_r; len_nxt = len_r; k_nxt = k_r; ph_nxt = ph_r;
    acc_nxt = acc_r; best_nxt = best_r; found_nxt = found_r; bv_nxt = bv_r;
    bk_nxt = bk_r; cst_nxt = cst_r; bc_nxt = bc_r; e_nxt = e_r;
    rd_v_nxt = 1'b0; rd_ph_nxt = ph_r; rd_lastk_nxt = 1'b0; rd_k_nxt = k_r[IdxW-1:0];
    raddr = '0; sq_start = 1'b0; dwe = 1'b0;
    ctl = '0; in_ready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CntW'(MaxPoints)) cnt_nxt = cnt_r + 1'b1;
          else ovf_nxt = 1'b1;
          if (in_data.last_point) begin
            i_nxt = '0; j_nxt = '0; ph_nxt = '0; state_nxt = S_DPAIR;
          end
        end
      end
      S_DPAIR: begin
        // Wait while the coordinate, difference, square and squared-sum registers fill.
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd3) state_nxt = S_DSQ;
      end
      S_DSQ: begin
        sq_start = 1'b1; state_nxt = S_DRT;
      end
      S_DRT: begin
        if (sq_done) begin
          dwe = 1'b1; ph_nxt = '0; state_nxt = S_DPAIR;
          if (CntW'(j_r) + 1'b1 == cnt_r) begin
            j_nxt = '0;
            if (CntW'(i_r) + 1'b1 == cnt_r) begin
              ctl.init = 1'b1; vis_nxt = '0; vis_nxt[0] = 1'b1; len_nxt = CntW'(1);
              state_nxt = (cnt_r > 1) ? S_SUM : S_EMIT;
              j_nxt = '0; k_nxt = '0; found_nxt = 1'b0; acc_nxt = '0; e_nxt = '0;
            end else i_nxt = i_r + 1'b1;
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_SUM: begin
        // For each unvisited j, issue reads d(tour[k], j) for all k, then compare.
        if (vis_r[j_r]) begin
          if (CntW'(j_r) + 1'b1 == cnt_r) begin
            k_nxt = '0; ph_nxt = '0; state_nxt = S_COST;
          end else j_nxt = j_r + 1'b1;
        end else begin
          raddr = {tk, j_r}; rd_v_nxt = 1'b1;
          rd_lastk_nxt = (k_r + 1'b1 == len_r);
          if (k_r + 1'b1 == len_r) begin k_nxt = '0; state_nxt = S_SACC; end
          else k_nxt = k_r + 1'b1;
        end
        if (rd_v_r) acc_nxt = acc_r + SumW'(rdata_r);
      end
      S_SACC: begin
        if (rd_v_r) begin
          acc_nxt = acc_r + SumW'(rdata_r);
          if (!found_r || acc_nxt < best_r) begin
            found_nxt = 1'b1; best_nxt = acc_nxt; bv_nxt = j_r;
          end
          acc_nxt = '0;
          state_nxt = S_SUM;
          if (CntW'(j_r) + 1'b1 == cnt_r) begin
            k_nxt = '0; ph_nxt = '0; state_nxt = S_COST;
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_COST: begin
        // Three reads per k: d(a,p), d(b,p), d(a,b).
        unique case (ph_r)
          2'd0: raddr = {tk, bv_r};
          2'd1: raddr = {tk1, bv_r};
          default: raddr = {tk, tk1};
        endcase
        rd_v_nxt = 1'b1; rd_ph_nxt = ph_r; rd_k_nxt = k_r[IdxW-1:0];
        rd_lastk_nxt = (k_r + 1'b1 == len_r);
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          if (k_r + 1'b1 == len_r) state_nxt = S_CACC;
          else k_nxt = k_r + 1'b1;
        end else ph_nxt = ph_r + 1'b1;
        if (rd_v_r) begin
          unique case (rd_ph_r)
            2'd0: cst_nxt = (SumW+1)'(rdata_r);
            2'd1: cst_nxt = cst_r + (SumW+1)'(rdata_r);
            default: begin
              cst_nxt = cst_r - (SumW+1)'(rdata_r);
              if (rd_k_r == '0 || cst_nxt < bc_r) begin bc_nxt = cst_nxt; bk_nxt = rd_k_r; end
            end
          endcase
        end
      end
      S_CACC: begin
        cst_nxt = cst_r - (SumW+1)'(rdata_r);
        if (rd_k_r == '0 || cst_nxt < bc_r) begin bc_nxt = cst_nxt; bk_nxt = rd_k_r; end
        state_nxt = S_INS;
      end
      S_INS: begin
        ctl.insert = 1'b1; ctl.pos = bk_r + 1'b1; ctl.vtx = bv_r;
        vis_nxt[bv_r] = 1'b1; len_nxt = len_r + 1'b1;
        j_nxt = '0; k_nxt = '0; found_nxt = 1'b0; acc_nxt = '0;
        state_nxt = (len_r + 1'b1 == cnt_r) ? S_EMIT : S_SUM;
      end
      S_EMIT: begin
        if (out_ready) begin
          e_nxt = e_r + 1'b1;
          if (e_r + 1'b1 == cnt_r) begin
            cnt_nxt = '0; ovf_nxt = 1'b0; vis_nxt = '0; state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign out_valid = (state_r == S_EMIT);
  assign out_data.tour_vertex = 6'(tour[e_r[IdxW-1:0]]);
  assign out_data.last_vertex = (e_r + 1'b1 == cnt_r);
  assign out_data.status = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; vis_r <= '0; rd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; vis_r <= vis_nxt;
      rd_v_r <= rd_v_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; len_r <= len_nxt; k_r <= k_nxt; ph_r <= ph_nxt;
    acc_r <= acc_nxt; best_r <= best_nxt; found_r <= found_nxt; bv_r <= bv_nxt;
    bk_r <= bk_nxt; cst_r <= cst_nxt; bc_r <= bc_nxt; e_r <= e_nxt;
    rd_ph_r <= rd_ph_nxt; rd_lastk_r <= rd_lastk_nxt; rd_k_r <= rd_k_nxt;
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxPoints)) else $error("point count past capacity");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0) else $error("emitting with no points");
  a_ins_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> !vis_r[bv_r]) else $error("inserting visited point");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("load during emit");
`endif

endmodule
